>>> rtl/core/assert_macros.svh
// assertion macros, empty when synthesized
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ADPCM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("adpcm assertion failed");
`define ADPCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adpcm implication failed");
`else
`define ADPCM_ASSERT(label, clk, rst_n, prop)
`define ADPCM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/adpcm_pkg.sv
`default_nettype none

package adpcm_pkg;

    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int SAMPLE_W     = 16;
    localparam int BYTE_W       = 8;
    localparam int NIB_W        = 4;
    localparam int EXP_W        = 4;
    localparam int PRED_W       = 3;
    localparam int FRAME_POS_W  = 3;
    localparam int COUNT_W      = 32;
    localparam int COEF_REGS    = 4;
    localparam int ACC_W        = 34;
    localparam int FRAC_SHIFT   = 11;
    localparam int ROUND_BIAS   = 1024;
    localparam int PROD_W       = 2 * SAMPLE_W;

    localparam logic [PRED_W-1:0]      PRED_MAX      = 3'd7;
    localparam logic [FRAME_POS_W-1:0] FRAME_HDR_POS = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_01       = 3'd0,
        CFG_COEF_23       = 3'd1,
        CFG_COEF_45       = 3'd2,
        CFG_COEF_67       = 3'd3,
        CFG_START_HIST1   = 3'd4,
        CFG_START_HIST2   = 3'd5,
        CFG_SAMPLE_COUNT  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] c1;
        logic signed [SAMPLE_W-1:0] c2;
        logic signed [SAMPLE_W-1:0] hist1;
        logic signed [SAMPLE_W-1:0] hist2;
        logic        [EXP_W-1:0]    exponent;
    } pred_ctx_t;

endpackage

`default_nettype wire

>>> rtl/core/dsp_adpcm_decoder_top.sv
// a data byte's first sample goes through the byte holding stage and the output word
// register, and out_stall can hold it between; its two codes are chained through one
// predictor unit, high nibble first; a header byte or a byte dropped after the stream
// ends gives no sample; reset clears coefficients, start histories, sample count and
// decoder state, not byte or output data; nothing decodes till sample_count is written
`default_nettype none

`include "assert_macros.svh"

module dsp_adpcm_decoder_top
    import adpcm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [BYTE_W-1:0]     data_byte,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [SAMPLE_W-1:0] pcm_sample,
    output logic                       last_of_byte,
    output logic                       end_of_stream
);

    logic [CFG_W-1:0]           coef_reg [COEF_REGS];
    logic [SAMPLE_W-1:0]        start_hist1_reg;
    logic [SAMPLE_W-1:0]        start_hist2_reg;
    logic [COUNT_W-1:0]         samples_left_reg;
    logic [FRAME_POS_W-1:0]     frame_pos_reg;
    logic [PRED_W-1:0]          pred_reg;
    logic [EXP_W-1:0]           exp_reg;
    logic signed [SAMPLE_W-1:0] hist1_reg;
    logic signed [SAMPLE_W-1:0] hist2_reg;

    logic                       item_valid_reg;
    logic [BYTE_W-1:0]          item_byte_reg;
    logic                       item_phase_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_last_reg;
    logic                       out_eos_reg;

    logic                       out_free;
    logic                       is_drop;
    logic                       is_header;
    logic                       is_decode;
    logic                       out_load;
    logic                       last_one;
    logic                       item_done;
    logic                       in_take;
    logic [CFG_W-1:0]           coef_pair;
    logic [2*SAMPLE_W-1:0]      coef_half;
    logic [NIB_W-1:0]           code;
    pred_ctx_t                  ctx;
    logic signed [SAMPLE_W-1:0] calc_sample;

    always_comb
    begin
        out_free  = !out_valid_reg || !out_stall;
        is_drop   = (samples_left_reg == '0);
        is_header = (frame_pos_reg == FRAME_HDR_POS);
        is_decode = item_valid_reg && !is_drop && !is_header;
        out_load  = is_decode && out_free;
        last_one  = (samples_left_reg == COUNT_W'(1));
        item_done = item_valid_reg
                  && (is_drop || is_header || (out_load && (item_phase_reg || last_one)));
        in_stall  = item_valid_reg && !item_done;
        in_take   = in_valid && !in_stall;

        coef_pair = coef_reg[pred_reg[PRED_W-1:1]];
        coef_half = pred_reg[0] ? coef_pair[CFG_W-1:2*SAMPLE_W] : coef_pair[2*SAMPLE_W-1:0];
        code      = item_phase_reg ? item_byte_reg[NIB_W-1:0] : item_byte_reg[BYTE_W-1:NIB_W];

        ctx.c1       = coef_half[SAMPLE_W-1:0];
        ctx.c2       = coef_half[2*SAMPLE_W-1:SAMPLE_W];
        ctx.hist1    = hist1_reg;
        ctx.hist2    = hist2_reg;
        ctx.exponent = exp_reg;
    end

    adpcm_sample_calc u_calc
    (
        .ctx    (ctx),
        .code   (code),
        .sample (calc_sample)
    );

    // config, decoder state and the byte holding stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
            start_hist1_reg  <= '0;
            start_hist2_reg  <= '0;
            samples_left_reg <= '0;
            frame_pos_reg    <= '0;
            pred_reg         <= '0;
            exp_reg          <= '0;
            hist1_reg        <= '0;
            hist2_reg        <= '0;
            item_valid_reg   <= 1'b0;
            item_phase_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_COEF_01, CFG_COEF_23, CFG_COEF_45, CFG_COEF_67:
                    begin
                        coef_reg[cfg_index[1:0]] <= cfg_data;
                    end
                    CFG_START_HIST1:
                    begin
                        start_hist1_reg <= cfg_data[SAMPLE_W-1:0];
                    end
                    CFG_START_HIST2:
                    begin
                        start_hist2_reg <= cfg_data[SAMPLE_W-1:0];
                    end
                    CFG_SAMPLE_COUNT:
                    begin
                        samples_left_reg <= cfg_data[COUNT_W-1:0];
                        frame_pos_reg    <= FRAME_HDR_POS;
                        pred_reg         <= '0;
                        exp_reg          <= '0;
                        hist1_reg        <= start_hist1_reg;
                        hist2_reg        <= start_hist2_reg;
                        item_phase_reg   <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (item_valid_reg && !is_drop)
            begin
                if (is_header)
                begin
                    pred_reg      <= item_byte_reg[BYTE_W-1] ? PRED_MAX
                                                             : item_byte_reg[BYTE_W-2:NIB_W];
                    exp_reg       <= item_byte_reg[EXP_W-1:0];
                    frame_pos_reg <= frame_pos_reg + FRAME_POS_W'(1);
                end
                else if (out_load)
                begin
                    hist2_reg        <= hist1_reg;
                    hist1_reg        <= calc_sample;
                    samples_left_reg <= samples_left_reg - COUNT_W'(1);
                    if (item_phase_reg || last_one)
                    begin
                        item_phase_reg <= 1'b0;
                        frame_pos_reg  <= frame_pos_reg + FRAME_POS_W'(1);
                    end
                    else
                    begin
                        item_phase_reg <= 1'b1;
                    end
                end
            end

            if (in_take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_done)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_byte_reg <= data_byte;
        end
        if (out_load)
        begin
            out_sample_reg <= calc_sample;
            out_last_reg   <= item_phase_reg || last_one;
            out_eos_reg    <= last_one;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign pcm_sample    = out_sample_reg;
    assign last_of_byte  = out_last_reg;
    assign end_of_stream = out_eos_reg;

    `ADPCM_ASSERT_IMP(a_eos_is_last, clk, rst_n, out_valid_reg, !out_eos_reg || out_last_reg)
    `ADPCM_ASSERT_IMP(a_phase_mid_frame, clk, rst_n, item_phase_reg, frame_pos_reg != FRAME_HDR_POS)
    `ADPCM_ASSERT_IMP(a_no_word_when_done, clk, rst_n, samples_left_reg == '0, !out_load)

endmodule

`default_nettype wire

>>> rtl/core/adpcm_sample_calc.sv
`default_nettype none

module adpcm_sample_calc
    import adpcm_pkg::*;
(
    input  var pred_ctx_t                  ctx,
    input  wire logic [NIB_W-1:0]          code,
    output logic signed [SAMPLE_W-1:0]     sample
);

    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND     = ACC_W'(ROUND_BIAS);

    logic signed [ACC_W-1:0]  nib_ext;
    logic signed [ACC_W-1:0]  scaled;
    logic signed [PROD_W-1:0] prod1;
    logic signed [PROD_W-1:0] prod2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;

    always_comb
    begin
        nib_ext = {{(ACC_W-NIB_W){code[NIB_W-1]}}, code};
        scaled  = (nib_ext <<< ctx.exponent) <<< FRAC_SHIFT;
        prod1   = ctx.c1 * ctx.hist1;
        prod2   = ctx.c2 * ctx.hist2;
        acc     = scaled + RND
                + {{(ACC_W-PROD_W){prod1[PROD_W-1]}}, prod1}
                + {{(ACC_W-PROD_W){prod2[PROD_W-1]}}, prod2};
        shifted = acc >>> FRAC_SHIFT;
        if (shifted > SAT_MAX)
        begin
            sample = SAT_MAX[SAMPLE_W-1:0];
        end
        else if (shifted < SAT_MIN)
        begin
            sample = SAT_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            sample = shifted[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire
